// ===== design/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg
// Shared constants, result kind codes and character tables for the
// server-sent-events stream parser.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int NAME_MAX_DEF = 32;
  localparam int MSG_LEN      = 7;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  function automatic logic [7:0] data_char(input logic [2:0] i);
    case (i)
      3'd0: return 8'h64;   // d
      3'd1: return 8'h61;   // a
      3'd2: return 8'h74;   // t
      3'd3: return 8'h61;   // a
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] event_char(input logic [2:0] i);
    case (i)
      3'd0: return 8'h65;   // e
      3'd1: return 8'h76;   // v
      3'd2: return 8'h65;   // e
      3'd3: return 8'h6e;   // n
      3'd4: return 8'h74;   // t
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] msg_char(input logic [2:0] i);
    case (i)
      3'd0: return 8'h6d;   // m
      3'd1: return 8'h65;   // e
      3'd2: return 8'h73;   // s
      3'd3: return 8'h73;   // s
      3'd4: return 8'h61;   // a
      3'd5: return 8'h67;   // g
      3'd6: return 8'h65;   // e
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ===== design/sse_ram.sv =====
// ----------------------------------------------------------------------------
// sse_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sse_pkg::NAME_MAX_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sse_stream_parser.sv =====
// ----------------------------------------------------------------------------
// sse_stream_parser
// Server-sent-events line parser, one stream byte per input transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_opcode selects a stream byte or a
// clear; in_byte carries the byte. Result channel (out_valid/out_ready):
// out_kind, out_byte, out_last, out_name_truncated, one result per transfer.
// Ordinary bytes give zero or one result, registered in the cycle after the
// input transfer; one byte per cycle is taken while the receiver keeps up.
// A blank line that closes a frame with data holds in_ready low while the
// event name is streamed from the name RAM: a RAM read, then the N stored
// name bytes, then the end marker; or the default name "message" and the
// end marker when no name is stored.
// A clear transfer gives one abort result if a data field of the frame has
// already opened, and returns the parser to its idle state.
// Reset (rst_n low, synchronous) empties the output register and returns
// the line state to start of line; the name RAM is not cleared, only
// entries below the stored length are read.
// A stalled receiver holds the result in the output register; a new input
// is taken in the same cycle the held result is transferred.
// ----------------------------------------------------------------------------
module sse_stream_parser #(
  parameter int NAME_MAX = sse_pkg::NAME_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_name_truncated
);

  localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int LW = $clog2(NAME_MAX + 1);
  localparam int IW = (LW > 3) ? LW : 3;
  localparam logic [LW-1:0] NAME_FULL = LW'(NAME_MAX);
  localparam logic [IW-1:0] MSG_LAST  = IW'(sse_pkg::MSG_LEN - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NAME,
    S_END
  } state_t;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_COMMENT   = 4'd1,
    PH_IGNORE    = 4'd2,
    PH_FIELD_D   = 4'd3,
    PH_FIELD_E   = 4'd4,
    PH_DATA_SP   = 4'd5,
    PH_DATA_VAL  = 4'd6,
    PH_EVENT_SP  = 4'd7,
    PH_EVENT_VAL = 4'd8
  } phase_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [2:0]      mc_r, mc_nxt;
  logic            cr_r, cr_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic            open_r, open_nxt;
  logic            msg_r, msg_nxt;
  logic            pend_r, pend_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;

  sse_pkg::kind_t  out_kind_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic            out_trunc_r;

  logic            out_free;
  logic            acc;
  logic            skip;
  logic            is_cr, is_lf, is_colon, is_sp;
  logic            do_open, do_store;
  logic            load;
  sse_pkg::kind_t  ld_kind;
  logic [7:0]      ld_byte;
  logic            ld_last;
  logic            ld_trunc;
  logic [IW-1:0]   idx_inc;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  sse_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_name_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign is_cr    = (in_byte == sse_pkg::CHAR_CR);
  assign is_lf    = (in_byte == sse_pkg::CHAR_LF);
  assign is_colon = (in_byte == sse_pkg::CHAR_COLON);
  assign is_sp    = (in_byte == sse_pkg::CHAR_SPACE);
  assign skip     = cr_r && is_lf;
  assign idx_inc  = idx_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mc_nxt    = mc_r;
    cr_nxt    = cr_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    open_nxt  = open_r;
    msg_nxt   = msg_r;
    pend_nxt  = pend_r;
    idx_nxt   = idx_r;
    do_open   = 1'b0;
    do_store  = 1'b0;
    load      = 1'b0;
    ld_kind   = sse_pkg::KIND_DATA;
    ld_byte   = 8'h00;
    ld_last   = 1'b1;
    ld_trunc  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = len_r[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_opcode == sse_pkg::OP_CLEAR) begin
            if (open_r) begin
              load    = 1'b1;
              ld_kind = sse_pkg::KIND_ABORT;
            end
            cr_nxt    = 1'b0;
            phase_nxt = PH_START;
            mc_nxt    = 3'd0;
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            open_nxt  = 1'b0;
          end else begin
            cr_nxt = 1'b0;
            if (!skip) begin
              if (is_cr || is_lf) begin
                // line end
                cr_nxt    = is_cr;
                phase_nxt = PH_START;
                mc_nxt    = 3'd0;
                case (phase_r)
                  PH_START: begin
                    if (open_r) begin
                      state_nxt = S_NAME;
                      idx_nxt   = '0;
                      pend_nxt  = 1'b0;
                      msg_nxt   = (len_r == '0);
                    end else begin
                      len_nxt = '0;
                      ovf_nxt = 1'b0;
                    end
                  end
                  PH_FIELD_D: begin
                    if (mc_r == 3'd4) begin
                      do_open = 1'b1;
                    end
                  end
                  PH_FIELD_E: begin
                    if (mc_r == 3'd5) begin
                      len_nxt = '0;
                      ovf_nxt = 1'b0;
                    end
                  end
                  default: ;
                endcase
              end else begin
                case (phase_r)
                  PH_START: begin
                    if (is_colon) begin
                      phase_nxt = PH_COMMENT;
                    end else if (in_byte == sse_pkg::data_char(3'd0)) begin
                      phase_nxt = PH_FIELD_D;
                      mc_nxt    = 3'd1;
                    end else if (in_byte == sse_pkg::event_char(3'd0)) begin
                      phase_nxt = PH_FIELD_E;
                      mc_nxt    = 3'd1;
                    end else begin
                      phase_nxt = PH_IGNORE;
                    end
                  end
                  PH_FIELD_D: begin
                    if (mc_r < 3'd4 && in_byte == sse_pkg::data_char(mc_r)) begin
                      mc_nxt = mc_r + 3'd1;
                    end else if (mc_r == 3'd4 && is_colon) begin
                      do_open   = 1'b1;
                      phase_nxt = PH_DATA_SP;
                    end else begin
                      phase_nxt = PH_IGNORE;
                    end
                  end
                  PH_FIELD_E: begin
                    if (mc_r < 3'd5 && in_byte == sse_pkg::event_char(mc_r)) begin
                      mc_nxt = mc_r + 3'd1;
                    end else if (mc_r == 3'd5 && is_colon) begin
                      len_nxt   = '0;
                      ovf_nxt   = 1'b0;
                      phase_nxt = PH_EVENT_SP;
                    end else begin
                      phase_nxt = PH_IGNORE;
                    end
                  end
                  PH_DATA_SP: begin
                    phase_nxt = PH_DATA_VAL;
                    if (!is_sp) begin
                      load    = 1'b1;
                      ld_byte = in_byte;
                    end
                  end
                  PH_DATA_VAL: begin
                    load    = 1'b1;
                    ld_byte = in_byte;
                  end
                  PH_EVENT_SP: begin
                    phase_nxt = PH_EVENT_VAL;
                    do_store  = !is_sp;
                  end
                  PH_EVENT_VAL: begin
                    do_store = 1'b1;
                  end
                  PH_COMMENT: ;
                  default: begin
                    phase_nxt = PH_IGNORE;
                  end
                endcase
              end
            end
          end
        end

        // joining newline goes out when the next data field opens
        if (do_open) begin
          if (open_r) begin
            load    = 1'b1;
            ld_byte = sse_pkg::CHAR_LF;
          end
          open_nxt = 1'b1;
        end

        if (do_store) begin
          if (len_r < NAME_FULL) begin
            ram_we  = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end

      S_NAME: begin
        if (msg_r) begin
          if (out_free) begin
            load    = 1'b1;
            ld_kind = sse_pkg::KIND_NAME;
            ld_byte = sse_pkg::msg_char(idx_r[2:0]);
            ld_last = 1'b0;
            if (idx_r == MSG_LAST) begin
              state_nxt = S_END;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end else if (!pend_r) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
        end else if (out_free) begin
          load    = 1'b1;
          ld_kind = sse_pkg::KIND_NAME;
          ld_byte = ram_rdata;
          ld_last = 1'b0;
          if (idx_inc == IW'(len_r)) begin
            state_nxt = S_END;
            pend_nxt  = 1'b0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
            idx_nxt   = idx_inc;
          end
        end
      end

      S_END: begin
        if (out_free) begin
          load      = 1'b1;
          ld_kind   = sse_pkg::KIND_END;
          ld_trunc  = ovf_r;
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          open_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_START;
      mc_r        <= 3'd0;
      cr_r        <= 1'b0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      open_r      <= 1'b0;
      msg_r       <= 1'b0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mc_r        <= mc_nxt;
      cr_r        <= cr_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      open_r      <= open_nxt;
      msg_r       <= msg_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r  <= ld_kind;
      out_byte_r  <= ld_byte;
      out_last_r  <= ld_last;
      out_trunc_r <= ld_trunc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_name_truncated = out_trunc_r;

endmodule

// ===== design/sse_checker.sv =====
// ----------------------------------------------------------------------------
// sse_checker
// Port-level checks for the server-sent-events stream parser.
// ----------------------------------------------------------------------------
module sse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_name_truncated
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_last) && $stable(out_name_truncated))
    else $error("result changed while stalled");

  // truncation flag only on an end marker
  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sse_pkg::KIND_END |-> !out_name_truncated)
    else $error("truncation flag outside end marker");

  // end and abort markers carry no byte and close the input's results
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == sse_pkg::KIND_END || out_kind == sse_pkg::KIND_ABORT)
      |-> out_byte == 8'h00 && out_last)
    else $error("bad end or abort marker");

  // a name byte is always followed by more of the frame
  a_name_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sse_pkg::KIND_NAME |-> !out_last)
    else $error("name byte marked last");

  // no input taken while a name is streaming out
  a_name_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sse_pkg::KIND_NAME |-> !in_ready)
    else $error("input taken during name transfer");

endmodule

bind sse_stream_parser sse_checker u_sse_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_byte           (out_byte),
  .out_last           (out_last),
  .out_name_truncated (out_name_truncated)
);
